// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker file of the Bezier evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checks a property on every rising edge of clk, reset cycles included.
`define ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/bcpe_pkg.sv -----
// Package with the constants and codes of the Bezier curve point evaluator.
package bcpe_pkg;

  // Sizing of the curve, the coordinates and the curve parameter.
  localparam int MAX_DEGREE  = 5;
  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int NPTS        = MAX_DEGREE + 1;

  // Field widths on the ports.
  localparam int KIND_BITS   = 1;
  localparam int PIDX_BITS   = 3;
  localparam int T_BITS      = T_FRAC_BITS + 1;
  localparam int DEG_BITS    = 3;

  // Internal widths: fixed-point coordinate, control point index, counters.
  localparam int FIX_BITS    = COORD_BITS + T_FRAC_BITS;
  localparam int DIFF_BITS   = FIX_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + T_BITS + 1;
  localparam int WIDX_BITS   = (NPTS > 1) ? $clog2(NPTS) : 1;
  localparam int CNT_BITS    = $clog2(NPTS + 1);

  // Configuration port.
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int REG_CURVE_DEGREE = 0;
  localparam logic [DEG_BITS-1:0] DEGREE_RESET = DEG_BITS'(1);

  // Item kinds.
  localparam logic [KIND_BITS-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_BITS-1:0] KIND_EVAL = 1'b1;

  // One in Q1.T_FRAC_BITS.
  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;

endpackage

// ----- rtl/bezier_curve_point_eval.sv -----
// Bezier curve point evaluator: control point store, de Casteljau sequencer, APB register.
//
//   channel   direction  handshake          payload
//   in        sink       in_valid/in_ready  kind, point_index, point_x, point_y, param_t
//   out       source     out_valid/out_ready curve_x, curve_y
//   apb       sink       psel/penable/pready paddr, pwdata, prdata (curve_degree)
//
// A load beat is taken and the block stays ready.
// An evaluate beat keeps the block busy while the one interpolator per axis performs
// every de Casteljau step for degree d, one step at a time.
// The result is written to the output register when the last step ends and that
// register is free; a stalled result holds the sequencer until it is taken.
// Synchronous reset clears the sequencer, the output valid and curve_degree (to 1).
module bezier_curve_point_eval (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [bcpe_pkg::KIND_BITS-1:0]           kind,
  input  logic [bcpe_pkg::PIDX_BITS-1:0]           point_index,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0]   point_x,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0]   point_y,
  input  logic [bcpe_pkg::T_BITS-1:0]              param_t,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [bcpe_pkg::COORD_BITS-1:0]   curve_x,
  output logic signed [bcpe_pkg::COORD_BITS-1:0]   curve_y,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [bcpe_pkg::ADDR_BITS-1:0]           paddr,
  input  logic [bcpe_pkg::DATA_BITS-1:0]           pwdata,
  output logic [bcpe_pkg::DATA_BITS-1:0]           prdata,
  output logic                                     pready
);

  localparam int NPTS  = bcpe_pkg::NPTS;
  localparam int FIX   = bcpe_pkg::FIX_BITS;
  localparam int TFRAC = bcpe_pkg::T_FRAC_BITS;
  localparam int CNT   = bcpe_pkg::CNT_BITS;
  localparam int WIDX  = bcpe_pkg::WIDX_BITS;
  localparam int AXES  = 2;
  localparam int ADDR_BITS_IDX = 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  typedef logic signed [FIX-1:0] fix_t;

  logic [1:0]                               state;
  logic [bcpe_pkg::DEG_BITS-1:0]            curve_degree;
  logic signed [bcpe_pkg::COORD_BITS-1:0]   store_x [NPTS];
  logic signed [bcpe_pkg::COORD_BITS-1:0]   store_y [NPTS];
  fix_t                                     w [AXES][NPTS];
  fix_t                                     w_next [AXES][NPTS];
  fix_t                                     wp [AXES][NPTS+2];
  fix_t                                     q [AXES];
  fix_t                                     rnd [AXES];
  logic [CNT-1:0]                           len;
  logic [CNT-1:0]                           left;
  logic [CNT-1:0]                           len_next;
  logic [CNT-1:0]                           left_next;
  logic [bcpe_pkg::T_BITS-1:0]              t_reg;
  logic [bcpe_pkg::T_BITS-1:0]              t_clamp;
  logic [bcpe_pkg::DEG_BITS-1:0]            deg_eff;
  logic                                     last;
  logic [WIDX-1:0]                          widx;
  logic                                     done;
  logic                                     out_free;
  logic                                     reg_wr;
  logic                                     in_fire;

  // APB: always ready, one register at index zero.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_BITS_IDX] == 1'b0) begin
      prdata = bcpe_pkg::DATA_BITS'(curve_degree);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_degree <= bcpe_pkg::DEGREE_RESET;
    end else if (reg_wr) begin
      unique case (32'(paddr[ADDR_BITS_IDX]))
        bcpe_pkg::REG_CURVE_DEGREE: curve_degree <= pwdata[bcpe_pkg::DEG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input side decode: clamp t and the degree at the beat.
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign t_clamp  = (param_t > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : param_t;
  assign deg_eff  = (curve_degree > bcpe_pkg::DEG_BITS'(bcpe_pkg::MAX_DEGREE)) ?
                    bcpe_pkg::DEG_BITS'(bcpe_pkg::MAX_DEGREE) : curve_degree;

  // Control point store, written by load beats with an index in range.
  always_ff @(posedge clk) begin
    if (in_fire && (kind == bcpe_pkg::KIND_LOAD) &&
        (32'(point_index) <= bcpe_pkg::MAX_DEGREE)) begin
      store_x[point_index[WIDX-1:0]] <= point_x;
      store_y[point_index[WIDX-1:0]] <= point_y;
    end
  end

  // One interpolation step per axis on the two front entries of the queue.
  always_comb begin
    logic signed [bcpe_pkg::DIFF_BITS-1:0] diff;
    logic signed [bcpe_pkg::PROD_BITS-1:0] prod;
    logic signed [bcpe_pkg::DIFF_BITS-1:0] sum;
    for (int a = 0; a < AXES; a++) begin
      diff = bcpe_pkg::DIFF_BITS'(w[a][1]) - bcpe_pkg::DIFF_BITS'(w[a][0]);
      prod = bcpe_pkg::PROD_BITS'(diff) *
             bcpe_pkg::PROD_BITS'($signed({1'b0, t_reg}));
      sum  = bcpe_pkg::DIFF_BITS'(w[a][0]) +
             $signed(prod[TFRAC +: bcpe_pkg::DIFF_BITS]);
      q[a] = sum[FIX-1:0];
    end
  end

  // Queue update: pop one entry (two at the end of a round) and push the new point.
  assign last = (left == CNT'(1));
  assign widx = last ? WIDX'(len - CNT'(2)) : WIDX'(len - CNT'(1));
  assign done = (len == CNT'(1));

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < NPTS; k++) begin
        wp[a][k] = w[a][k];
      end
      wp[a][NPTS]   = '0;
      wp[a][NPTS+1] = '0;
      for (int k = 0; k < NPTS; k++) begin
        w_next[a][k] = last ? wp[a][k+2] : wp[a][k+1];
      end
      w_next[a][widx] = q[a];
    end
    len_next  = last ? len - CNT'(1) : len;
    left_next = last ? len - CNT'(2) : left - CNT'(1);
  end

  // Truncate the final fixed-point value toward zero.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rnd[a] = w[a][0] + $signed({{bcpe_pkg::COORD_BITS{1'b0}},
                                  {TFRAC{w[a][0][FIX-1]}}});
    end
  end

  assign out_free = !out_valid || out_ready;

  // Sequencer and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire && (kind == bcpe_pkg::KIND_EVAL)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (done && out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // A finished point is posted; otherwise a taken result is retired.
      if ((state == ST_RUN) && done && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working queue, counters and result payload.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (in_fire && (kind == bcpe_pkg::KIND_EVAL)) begin
        for (int k = 0; k < NPTS; k++) begin
          w[0][k] <= {store_x[k], {TFRAC{1'b0}}};
          w[1][k] <= {store_y[k], {TFRAC{1'b0}}};
        end
        len   <= CNT'(deg_eff) + CNT'(1);
        left  <= CNT'(deg_eff);
        t_reg <= t_clamp;
      end
    end else if (!done) begin
      w    <= w_next;
      len  <= len_next;
      left <= left_next;
    end else if (out_free) begin
      curve_x <= rnd[0][TFRAC +: bcpe_pkg::COORD_BITS];
      curve_y <= rnd[1][TFRAC +: bcpe_pkg::COORD_BITS];
    end
  end

endmodule

// ----- rtl/bcpe_checker.sv -----
// Port-level checker for the Bezier curve point evaluator, bound to the top level.
`include "assert_macros.svh"

module bcpe_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic [bcpe_pkg::KIND_BITS-1:0]         kind,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x,
  input logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y
);

  // A result that is not taken stays on the port unchanged.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(curve_x) && $stable(curve_y))

  // Reset leaves the block ready with no result pending.
  `ASSERT_ALL(a_rst_state, clk, rst |=> in_ready && !out_valid)

  // An evaluate beat occupies the sequencer for at least the next cycle.
  `ASSERT_CLK(a_eval_busy, clk, rst, in_valid && in_ready && (kind == bcpe_pkg::KIND_EVAL) |=> !in_ready)

  // A load beat leaves the block ready for the next beat.
  `ASSERT_CLK(a_load_ready, clk, rst, in_valid && in_ready && (kind == bcpe_pkg::KIND_LOAD) |=> in_ready)

  // A new result appears only as the sequencer goes back to idle.
  `ASSERT_CLK(a_result_idle, clk, rst, $rose(out_valid) |-> in_ready)

endmodule

bind bezier_curve_point_eval bcpe_checker u_bcpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .kind      (kind),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .curve_x   (curve_x),
  .curve_y   (curve_y)
);

// ----- tb/sv/bezier_point_checker.sv -----
// Checker for the Bezier curve point evaluator: predicts each curve point and compares results.
module bezier_point_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [bcpe_pkg::KIND_BITS-1:0]         kind,
  input  logic [bcpe_pkg::PIDX_BITS-1:0]         point_index,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_y,
  input  logic [bcpe_pkg::T_BITS-1:0]            param_t,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bcpe_pkg::ADDR_BITS-1:0]         paddr,
  input  logic [bcpe_pkg::DATA_BITS-1:0]         pwdata,
  input  logic [bcpe_pkg::DATA_BITS-1:0]         prdata,
  input  logic                                   pready,
  output int                                     mismatches,
  output int                                     points_pending,
  output int                                     points_checked
);

  localparam logic [bcpe_pkg::ADDR_BITS-1:0] DEGREE_ADDR =
    bcpe_pkg::ADDR_BITS'(4 * bcpe_pkg::REG_CURVE_DEGREE);

  typedef struct packed {
    logic signed [bcpe_pkg::COORD_BITS-1:0] x;
    logic signed [bcpe_pkg::COORD_BITS-1:0] y;
  } curve_point_t;

  // Shadow copy of the control points and the degree register.
  logic signed [bcpe_pkg::COORD_BITS-1:0] ctrl_x [bcpe_pkg::NPTS];
  logic signed [bcpe_pkg::COORD_BITS-1:0] ctrl_y [bcpe_pkg::NPTS];
  logic [bcpe_pkg::DEG_BITS-1:0]          degree_reg;
  curve_point_t                           expected_points [$];

  // One axis by repeated fixed-point interpolation; each step floors, the end truncates.
  function automatic logic signed [bcpe_pkg::COORD_BITS-1:0] curve_axis(
    input bit on_y, input int deg, input longint t);
    longint acc [bcpe_pkg::NPTS];
    longint v;
    for (int i = 0; i <= deg; i++)
      acc[i] = longint'(on_y ? ctrl_y[i] : ctrl_x[i]) <<< bcpe_pkg::T_FRAC_BITS;
    for (int r = deg; r > 0; r--)
      for (int i = 0; i < r; i++)
        acc[i] = acc[i] + (((acc[i+1] - acc[i]) * t) >>> bcpe_pkg::T_FRAC_BITS);
    v = (acc[0] < 0) ? -((-acc[0]) >>> bcpe_pkg::T_FRAC_BITS) :
                       (acc[0] >>> bcpe_pkg::T_FRAC_BITS);
    return v[bcpe_pkg::COORD_BITS-1:0];
  endfunction

  // The curve point for one evaluate beat; t saturates at one and the degree at its maximum.
  function automatic curve_point_t predict_point(input logic [bcpe_pkg::T_BITS-1:0] t_in);
    curve_point_t p;
    longint t;
    int deg;
    t = (t_in > bcpe_pkg::T_ONE) ? longint'(bcpe_pkg::T_ONE) : longint'(t_in);
    deg = (degree_reg > bcpe_pkg::MAX_DEGREE) ? bcpe_pkg::MAX_DEGREE : int'(degree_reg);
    p.x = curve_axis(1'b0, deg, t);
    p.y = curve_axis(1'b1, deg, t);
    return p;
  endfunction

  always @(posedge clk) begin : watch
    curve_point_t due;
    if (rst) begin
      degree_reg = bcpe_pkg::DEGREE_RESET;
      expected_points.delete();
      mismatches = 0;
      points_pending = 0;
      points_checked = 0;
    end else begin
      // Register writes and read-backs at the degree address; other addresses are not tracked.
      if (psel && penable && pready && paddr == DEGREE_ADDR) begin
        if (pwrite) begin
          degree_reg = pwdata[bcpe_pkg::DEG_BITS-1:0];
        end else if (prdata !== bcpe_pkg::DATA_BITS'(degree_reg)) begin
          $error("prdata mismatch: expected %0d, got %0d", degree_reg, prdata);
          mismatches++;
        end
      end

      // Input beats: loads update the shadow store, evaluations queue a curve point.
      if (in_valid && in_ready) begin
        if (kind == bcpe_pkg::KIND_LOAD) begin
          if (point_index <= bcpe_pkg::MAX_DEGREE) begin
            ctrl_x[point_index] = point_x;
            ctrl_y[point_index] = point_y;
          end
        end else begin
          expected_points.push_back(predict_point(param_t));
        end
      end

      // Result beats are compared with the oldest queued curve point.
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("result beat with no curve point expected: x %0d, y %0d", curve_x, curve_y);
          mismatches++;
        end else begin
          due = expected_points.pop_front();
          if (due.x !== curve_x) begin
            $error("curve_x mismatch: expected %0d, got %0d", due.x, curve_x);
            mismatches++;
          end
          if (due.y !== curve_y) begin
            $error("curve_y mismatch: expected %0d, got %0d", due.y, curve_y);
            mismatches++;
          end
          points_checked++;
        end
      end
      points_pending = expected_points.size();
    end
  end

endmodule

// ----- tb/sv/bezier_curve_point_eval_tb.sv -----
// Testbench top of the Bezier curve point evaluator: clock, stimulus, pacing and verdict.
module bezier_curve_point_eval_tb;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int SEGMENT_ITEMS = 172;
  localparam int SEGMENTS      = 8;

  localparam logic [bcpe_pkg::ADDR_BITS-1:0] DEGREE_ADDR =
    bcpe_pkg::ADDR_BITS'(4 * bcpe_pkg::REG_CURVE_DEGREE);
  // The next register slot has no register behind it.
  localparam logic [bcpe_pkg::ADDR_BITS-1:0] SPARE_ADDR =
    bcpe_pkg::ADDR_BITS'(4 * (bcpe_pkg::REG_CURVE_DEGREE + 1));

  localparam logic [bcpe_pkg::COORD_BITS-1:0] COORD_MAX =
    {1'b0, {(bcpe_pkg::COORD_BITS-1){1'b1}}};
  localparam logic [bcpe_pkg::COORD_BITS-1:0] COORD_MIN =
    {1'b1, {(bcpe_pkg::COORD_BITS-1){1'b0}}};
  localparam logic [bcpe_pkg::COORD_BITS-1:0] COORD_NEG1 = '1;
  localparam logic [bcpe_pkg::T_BITS-1:0]     T_ALL_ONES = '1;
  localparam logic [bcpe_pkg::T_BITS-1:0]     T_LSB      = bcpe_pkg::T_BITS'(1);
  localparam logic [bcpe_pkg::T_BITS-1:0]     T_BELOW    = bcpe_pkg::T_ONE - T_LSB;
  localparam logic [bcpe_pkg::T_BITS-1:0]     T_ABOVE    = bcpe_pkg::T_ONE + T_LSB;
  localparam logic [bcpe_pkg::T_BITS-1:0]     T_HALF     = bcpe_pkg::T_ONE >> 1;

  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  logic                                   clk;
  logic                                   rst = 1'b1;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [bcpe_pkg::KIND_BITS-1:0]         kind = bcpe_pkg::KIND_LOAD;
  logic [bcpe_pkg::PIDX_BITS-1:0]         point_index = '0;
  logic signed [bcpe_pkg::COORD_BITS-1:0] point_x = '0;
  logic signed [bcpe_pkg::COORD_BITS-1:0] point_y = '0;
  logic [bcpe_pkg::T_BITS-1:0]            param_t = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x;
  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y;
  logic                                   psel = 1'b0;
  logic                                   penable = 1'b0;
  logic                                   pwrite = 1'b0;
  logic [bcpe_pkg::ADDR_BITS-1:0]         paddr = '0;
  logic [bcpe_pkg::DATA_BITS-1:0]         pwdata = '0;
  logic [bcpe_pkg::DATA_BITS-1:0]         prdata;
  logic                                   pready;

  int mismatches;
  int points_pending;
  int points_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int evals_sent = 0;
  int quiet_cycles = 0;
  int degree_plan [SEGMENTS] = '{2, 0, 5, 7, 1, 3, 6, 4};

  bezier_curve_point_eval uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .point_index(point_index), .point_x(point_x), .point_y(point_y),
    .param_t(param_t),
    .out_valid(out_valid), .out_ready(out_ready), .curve_x(curve_x), .curve_y(curve_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  bezier_point_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .point_index(point_index), .point_x(point_x), .point_y(point_y),
    .param_t(param_t),
    .out_valid(out_valid), .out_ready(out_ready), .curve_x(curve_x), .curve_y(curve_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .points_pending(points_pending),
    .points_checked(points_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random, at the rate of the current pacing mode.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_t mode);
    idle_pct  = (mode == PACE_SENDER)   ? 74 : (mode == PACE_BOTH) ? 25 : 0;
    stall_pct = (mode == PACE_RECEIVER) ? 74 : (mode == PACE_BOTH) ? 25 : 0;
  endtask

  // Point index of the given number, at the width of the port.
  function automatic logic [bcpe_pkg::PIDX_BITS-1:0] pidx(input int i);
    return bcpe_pkg::PIDX_BITS'(i);
  endfunction

  // Presents one beat after a random number of idle cycles and waits until it is taken.
  task automatic send_beat(input logic [bcpe_pkg::KIND_BITS-1:0] k,
                           input logic [bcpe_pkg::PIDX_BITS-1:0] idx,
                           input logic [bcpe_pkg::COORD_BITS-1:0] x,
                           input logic [bcpe_pkg::COORD_BITS-1:0] y,
                           input logic [bcpe_pkg::T_BITS-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    point_index <= idx;
    point_x     <= x;
    point_y     <= y;
    param_t     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (k == bcpe_pkg::KIND_EVAL) evals_sent++;
  endtask

  // Stops sending until every queued curve point has come back and the block is idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (points_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [bcpe_pkg::ADDR_BITS-1:0] addr,
                            input logic [bcpe_pkg::DATA_BITS-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register once the block is idle, then reads it back.
  task automatic write_register(input logic [bcpe_pkg::ADDR_BITS-1:0] addr, input int value);
    drain_results();
    apb_access(1'b1, addr, bcpe_pkg::DATA_BITS'(value));
    apb_access(1'b0, addr, '0);
  endtask

  // Mostly full-range values, with the extremes and the values around zero mixed in.
  function automatic logic [bcpe_pkg::COORD_BITS-1:0] random_coord();
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return $urandom_range(1) ? COORD_NEG1 : '0;
      default: return bcpe_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [bcpe_pkg::T_BITS-1:0] random_param();
    case ($urandom_range(9))
      0: return '0;
      1: return bcpe_pkg::T_ONE;
      2: return bcpe_pkg::T_BITS'($urandom_range(int'(T_ALL_ONES),
                                                 int'(bcpe_pkg::T_ONE) + 1));
      default: return bcpe_pkg::T_BITS'($urandom_range(int'(bcpe_pkg::T_ONE) - 1));
    endcase
  endfunction

  // Evaluations and in-range loads dominate; a few loads go to indexes the block ignores.
  task automatic random_beat(output bit counted);
    int pick;
    logic [bcpe_pkg::COORD_BITS-1:0] x;
    logic [bcpe_pkg::COORD_BITS-1:0] y;
    logic [bcpe_pkg::T_BITS-1:0] t;
    pick = $urandom_range(99);
    x = random_coord();
    y = random_coord();
    t = random_param();
    counted = 1'b1;
    if (pick < 58) begin
      send_beat(bcpe_pkg::KIND_EVAL, pidx($urandom_range(7)), x, y, t);
    end else if (pick < 95) begin
      send_beat(bcpe_pkg::KIND_LOAD, pidx($urandom_range(bcpe_pkg::MAX_DEGREE)), x, y, t);
    end else begin
      send_beat(bcpe_pkg::KIND_LOAD, pidx($urandom_range(7, bcpe_pkg::MAX_DEGREE + 1)),
                x, y, t);
      counted = 1'b0;
    end
  endtask

  initial begin
    int useful;
    bit counted;
    set_pace(PACE_NONE);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every control point with extreme coordinates before any evaluation.
    send_beat(bcpe_pkg::KIND_LOAD, pidx(0), COORD_MIN, COORD_MAX, '0);
    send_beat(bcpe_pkg::KIND_LOAD, pidx(1), COORD_MAX, COORD_MIN, '0);
    send_beat(bcpe_pkg::KIND_LOAD, pidx(2), '0, COORD_NEG1, T_ALL_ONES);
    send_beat(bcpe_pkg::KIND_LOAD, pidx(3), COORD_NEG1, '0, '0);
    send_beat(bcpe_pkg::KIND_LOAD, pidx(4), COORD_MAX, COORD_MAX, '0);
    send_beat(bcpe_pkg::KIND_LOAD, pidx(5), COORD_MIN, COORD_MIN, '0);
    // Loads beyond the last control point must leave the store alone.
    send_beat(bcpe_pkg::KIND_LOAD, pidx(6), COORD_MAX, COORD_MAX, '0);
    send_beat(bcpe_pkg::KIND_LOAD, pidx(7), COORD_NEG1, COORD_NEG1, '0);

    // Reset degree: the ends of t, the values next to them, and t above one.
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, '0);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, bcpe_pkg::T_ONE);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, T_LSB);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, T_BELOW);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(7), '0, '0, T_ALL_ONES);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, T_ABOVE);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, T_HALF);

    // Degree zero returns the first control point.
    write_register(DEGREE_ADDR, 0);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, bcpe_pkg::T_BITS'(12345));
    // Highest degree, then a degree above it that saturates.
    write_register(DEGREE_ADDR, bcpe_pkg::MAX_DEGREE);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, '0);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, T_HALF);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, T_BELOW);
    write_register(DEGREE_ADDR, 7);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, bcpe_pkg::T_BITS'(40000));
    // A write to an address with no register changes nothing.
    write_register(SPARE_ADDR, 3);
    send_beat(bcpe_pkg::KIND_EVAL, pidx(0), '0, '0, bcpe_pkg::T_BITS'(1000));

    // Random segments, each with its own degree and pacing mode.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_register(DEGREE_ADDR, degree_plan[seg]);
      set_pace(pace_t'(seg % 4));
      useful = 0;
      while (useful < SEGMENT_ITEMS) begin
        random_beat(counted);
        if (counted) useful++;
        if (useful == SEGMENT_ITEMS / 2 && counted) drain_results();
      end
    end

    drain_results();
    $display("Covered %0d input beats (%0d evaluations, %0d curve points checked)",
             beats_sent, evals_sent, points_checked);
    $display("over degrees 0 to 7, t up to the field maximum, and four channel pacing modes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- bezier_curve_point_eval.f -----
+incdir+rtl
rtl/bcpe_pkg.sv
rtl/bezier_curve_point_eval.sv
rtl/bcpe_checker.sv
tb/sv/bezier_point_checker.sv
tb/sv/bezier_curve_point_eval_tb.sv
